FILE: rtl/npc_pkg.sv
// Shared types, constants and helpers for the nearest palette color core.
// Used by npc_dist, npc_min and nearest_palette_color_core.
package npc_pkg;

  localparam int PAL_REGS   = 8;
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int SQ_W       = 2 * CH_W;
  localparam int DIST_W     = 18;
  localparam int SLOT_W     = 3;
  localparam int IDX_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_DATA_W = 8;

  localparam logic [COLOR_W-1:0] PAL_RESET [PAL_REGS] = '{
    24'hF870F8, 24'hF87090, 24'hF8A030, 24'hF8E331,
    24'h1EE000, 24'h16C0F8, 24'h0150F8, 24'h9808F8
  };

  typedef logic [PAL_REGS-1:0][COLOR_W-1:0] palette_t;

  typedef struct packed {
    logic              vld;
    logic [DIST_W-1:0] dist_sq;
    logic [SLOT_W-1:0] slot;
  } cand_t;

  // Lower slot sits in a; b wins only if a is invalid or b has a strictly smaller distance.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t res;
    res = a;
    if (b.vld && (!a.vld || (b.dist_sq < a.dist_sq))) begin
      res = b;
    end
    return res;
  endfunction

endpackage

FILE: rtl/nearest_palette_color_core.sv
// Top level of the nearest palette color core: palette registers and pipeline.
// Depends on npc_pkg, npc_dist and npc_min.
//
// Usage: send one RGB color per request on the s_ channel; the m_ channel
// returns the one-based index of the nearest palette entry by squared
// Euclidean distance, lowest index on a tie, values 1 to PALETTE_SIZE.
// Palette entries are written through cfg_we/cfg_index/cfg_data, one 24-bit
// entry (red 23:16, green 15:8, blue 7:0) per write; the user must write
// entries only while idle; the core itself does not enforce it. Pipeline: three
// distance stages, then three levels of the minimum tree, up to m_tvalid.
// Throughput: one request per cycle unless stalled; every stage has its own valid bit.
// Stall: when m_tready is low, results collect in the empty stages; s_tready
// drops only once all six stages hold a request. Nothing is lost or repeated.
// Reset: clears all valid bits and loads the default palette.
module nearest_palette_color_core #(
  parameter int PALETTE_SIZE = npc_pkg::PAL_REGS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [npc_pkg::COLOR_W-1:0]        s_tdata,   // red_in, green_in, blue_in
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [npc_pkg::OUT_DATA_W-1:0]     m_tdata,   // color_index, zero pad
  input  logic                               cfg_we,
  input  logic [npc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [npc_pkg::COLOR_W-1:0]        cfg_data
);

  npc_pkg::palette_t                      palette;
  npc_pkg::cand_t [npc_pkg::PAL_REGS-1:0] cands;
  logic                                   dist_valid;
  logic                                   dist_ready;
  logic [npc_pkg::IDX_W-1:0]              color_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < npc_pkg::PAL_REGS; i++) palette[i] <= npc_pkg::PAL_RESET[i];
    end else if (cfg_we) begin
      palette[cfg_index] <= cfg_data;
    end
  end

  npc_dist #(
    .PALETTE_SIZE(PALETTE_SIZE)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .red       (s_tdata[7:0]),
    .green     (s_tdata[15:8]),
    .blue      (s_tdata[23:16]),
    .palette   (palette),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .cands     (cands)
  );

  npc_min u_min (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dist_valid),
    .in_ready    (dist_ready),
    .cands       (cands),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .color_index (color_index)
  );

  assign m_tdata = {{(npc_pkg::OUT_DATA_W - npc_pkg::IDX_W){1'b0}}, color_index};

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (color_index != '0) &&
                 (color_index <= npc_pkg::IDX_W'(PALETTE_SIZE)))
    else $error("color index out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without an output stall");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid && s_tready)
    else $error("pipeline not empty after reset");

endmodule

FILE: rtl/npc_dist.sv
// Three-stage distance pipeline: channel differences, squares, per-entry sums.
// Depends on npc_pkg.
module npc_dist #(
  parameter int PALETTE_SIZE = npc_pkg::PAL_REGS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [npc_pkg::CH_W-1:0]               red,
  input  logic [npc_pkg::CH_W-1:0]               green,
  input  logic [npc_pkg::CH_W-1:0]               blue,
  input  npc_pkg::palette_t                      palette,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output npc_pkg::cand_t [npc_pkg::PAL_REGS-1:0] cands
);

  logic [npc_pkg::PAL_REGS-1:0][2:0][npc_pkg::CH_W-1:0] diff;
  logic [npc_pkg::PAL_REGS-1:0][2:0][npc_pkg::SQ_W-1:0] sq;
  logic [npc_pkg::PAL_REGS-1:0][2:0][npc_pkg::CH_W-1:0] diff_next;
  logic [npc_pkg::PAL_REGS-1:0][2:0][npc_pkg::SQ_W-1:0] sq_next;
  npc_pkg::cand_t [npc_pkg::PAL_REGS-1:0]                cands_next;
  logic [2:0][npc_pkg::CH_W-1:0]                         pix;
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign pix  = {red, green, blue};
  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;

  always_comb begin
    for (int i = 0; i < npc_pkg::PAL_REGS; i++) begin
      for (int c = 0; c < 3; c++) begin
        if (pix[c] > palette[i][c*npc_pkg::CH_W +: npc_pkg::CH_W]) begin
          diff_next[i][c] = pix[c] - palette[i][c*npc_pkg::CH_W +: npc_pkg::CH_W];
        end else begin
          diff_next[i][c] = palette[i][c*npc_pkg::CH_W +: npc_pkg::CH_W] - pix[c];
        end
        sq_next[i][c] = npc_pkg::SQ_W'(diff[i][c]) * npc_pkg::SQ_W'(diff[i][c]);
      end
      cands_next[i].vld     = (i < PALETTE_SIZE);
      cands_next[i].slot    = npc_pkg::SLOT_W'(i);
      cands_next[i].dist_sq = npc_pkg::DIST_W'(sq[i][0]) + npc_pkg::DIST_W'(sq[i][1])
                            + npc_pkg::DIST_W'(sq[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) diff <= diff_next;
    if (rdy2 && v1) sq <= sq_next;
    if (rdy3 && v2) cands <= cands_next;
  end

endmodule

FILE: rtl/npc_min.sv
// Registered three-level minimum tree over the eight candidates.
// Depends on npc_pkg.
module npc_min (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  npc_pkg::cand_t [npc_pkg::PAL_REGS-1:0] cands,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [npc_pkg::IDX_W-1:0]              color_index
);

  npc_pkg::cand_t [3:0] lvl1;
  npc_pkg::cand_t [1:0] lvl2;
  npc_pkg::cand_t       lvl3;
  npc_pkg::cand_t [3:0] lvl1_next;
  npc_pkg::cand_t [1:0] lvl2_next;
  npc_pkg::cand_t       lvl3_next;
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3 || out_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3;
  assign color_index = npc_pkg::IDX_W'(lvl3.slot) + npc_pkg::IDX_W'(1);

  always_comb begin
    for (int i = 0; i < 4; i++) lvl1_next[i] = npc_pkg::pick(cands[2*i], cands[2*i+1]);
    for (int i = 0; i < 2; i++) lvl2_next[i] = npc_pkg::pick(lvl1[2*i], lvl1[2*i+1]);
    lvl3_next = npc_pkg::pick(lvl2[0], lvl2[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) lvl1 <= lvl1_next;
    if (rdy2 && v1) lvl2 <= lvl2_next;
    if (rdy3 && v2) lvl3 <= lvl3_next;
  end

endmodule

FILE: bench/nearest_color_checker.sv
// Checker for the nearest palette color core: watches the color, result and
// palette write channels, predicts each color index and compares in order.
// Depends on npc_pkg for widths.
module nearest_color_checker #(
  parameter int PALETTE_SIZE = npc_pkg::PAL_REGS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [npc_pkg::COLOR_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [npc_pkg::OUT_DATA_W-1:0] m_tdata,   // color_index, zero pad
  input  logic                           cfg_we,
  input  logic [npc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npc_pkg::COLOR_W-1:0]    cfg_data,
  output int                             mismatch_count,
  output int                             inflight_count
);

  localparam logic [npc_pkg::COLOR_W-1:0] DEFAULT_PALETTE [npc_pkg::PAL_REGS] = '{
    24'hF870F8, 24'hF87090, 24'hF8A030, 24'hF8E331,
    24'h1EE000, 24'h16C0F8, 24'h0150F8, 24'h9808F8
  };

  logic [npc_pkg::COLOR_W-1:0] palette [npc_pkg::PAL_REGS];
  logic [npc_pkg::IDX_W-1:0]   expected_index_q [$];

  initial begin
    mismatch_count = 0;
    inflight_count = 0;
  end

  function automatic int channel_sq(input logic [npc_pkg::CH_W-1:0] a,
                                    input logic [npc_pkg::CH_W-1:0] b);
    int d;
    d = a;
    d = d - b;
    return d * d;
  endfunction

  function automatic logic [npc_pkg::IDX_W-1:0] nearest_entry(
    input logic [npc_pkg::COLOR_W-1:0] word
  );
    int best_dist;
    int sum_sq;
    logic [npc_pkg::IDX_W-1:0] best_idx;
    best_dist = 32'h7FFF_FFFF;
    best_idx  = npc_pkg::IDX_W'(1);
    for (int i = 0; i < PALETTE_SIZE && i < npc_pkg::PAL_REGS; i++) begin
      sum_sq = channel_sq(word[7:0],   palette[i][23:16])
             + channel_sq(word[15:8],  palette[i][15:8])
             + channel_sq(word[23:16], palette[i][7:0]);
      if (sum_sq < best_dist) begin
        best_dist = sum_sq;
        best_idx  = npc_pkg::IDX_W'(i + 1);
      end
    end
    return best_idx;
  endfunction

  always @(posedge clk) begin
    logic [npc_pkg::IDX_W-1:0] want;
    if (rst) begin
      for (int i = 0; i < npc_pkg::PAL_REGS; i++) palette[i] <= DEFAULT_PALETTE[i];
      expected_index_q.delete();
      inflight_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_index_q.push_back(nearest_entry(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_index_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_index_q.pop_front();
          if (m_tdata !== {{(npc_pkg::OUT_DATA_W-npc_pkg::IDX_W){1'b0}}, want}) begin
            $display("%0t: color index mismatch, expected %h, got %h", $time,
                     {{(npc_pkg::OUT_DATA_W-npc_pkg::IDX_W){1'b0}}, want}, m_tdata);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (cfg_we) palette[cfg_index] <= cfg_data;
      inflight_count <= expected_index_q.size();
    end
  end

endmodule

FILE: bench/testbench.sv
// Top of the nearest palette color bench: clock, reset, palette writes and
// color stimulus with random idling on both channels; verdict from the checker.
// Depends on npc_pkg, nearest_palette_color_core and nearest_color_checker.
module testbench;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 195;
  localparam int MAX_GAP         = 17;
  localparam int DRAIN_CYCLES    = 16;

  typedef enum int {
    PAL_DEFAULT, PAL_ZERO, PAL_WHITE, PAL_RANDOM, PAL_FEW_COLORS, PAL_CORNERS
  } palette_kind_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [npc_pkg::COLOR_W-1:0]    s_tdata   = '0;
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [npc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we    = 1'b0;
  logic [npc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [npc_pkg::COLOR_W-1:0]    cfg_data  = '0;

  logic send_idles = 1'b1;
  logic recv_idles = 1'b1;
  logic [npc_pkg::COLOR_W-1:0] palette_now [npc_pkg::PAL_REGS];
  int mismatch_count;
  int inflight_count;

  nearest_palette_color_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  nearest_color_checker checker_inst (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .inflight_count(inflight_count)
  );

  always #4 clk = ~clk;

  // rgb is red 23:16, green 15:8, blue 7:0; the stream puts red lowest
  task automatic send_color(input logic [npc_pkg::COLOR_W-1:0] rgb);
    int gap;
    gap = send_idles ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (inflight_count != 0) @(posedge clk);
  endtask

  task automatic write_palette();
    for (int i = 0; i < npc_pkg::PAL_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= npc_pkg::CFG_IDX_W'(i);
      cfg_data  <= palette_now[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic fill_palette(input palette_kind_t kind);
    logic [npc_pkg::COLOR_W-1:0] few [3];
    for (int k = 0; k < 3; k++) few[k] = npc_pkg::COLOR_W'($urandom());
    for (int i = 0; i < npc_pkg::PAL_REGS; i++) begin
      case (kind)
        PAL_DEFAULT:    palette_now[i] = npc_pkg::PAL_RESET[i];
        PAL_ZERO:       palette_now[i] = '0;
        PAL_WHITE:      palette_now[i] = '1;
        PAL_RANDOM:     palette_now[i] = npc_pkg::COLOR_W'($urandom());
        PAL_FEW_COLORS: palette_now[i] = few[$urandom_range(0, 2)];
        default: begin
          palette_now[i] = {{npc_pkg::CH_W{$urandom_range(0, 1) == 1}},
                            {npc_pkg::CH_W{$urandom_range(0, 1) == 1}},
                            {npc_pkg::CH_W{$urandom_range(0, 1) == 1}}};
        end
      endcase
    end
  endtask

  function automatic logic [npc_pkg::COLOR_W-1:0] random_color();
    logic [npc_pkg::COLOR_W-1:0] a;
    logic [npc_pkg::COLOR_W-1:0] b;
    logic [npc_pkg::COLOR_W-1:0] c;
    a = palette_now[$urandom_range(0, npc_pkg::PAL_REGS - 1)];
    b = palette_now[$urandom_range(0, npc_pkg::PAL_REGS - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: c = npc_pkg::COLOR_W'($urandom());
      3, 4:    c = a;
      5, 6: begin
        for (int k = 0; k < 3; k++)
          c[k*npc_pkg::CH_W +: npc_pkg::CH_W] = a[k*npc_pkg::CH_W +: npc_pkg::CH_W]
                                              + npc_pkg::CH_W'($urandom_range(0, 8) - 4);
      end
      7: begin
        for (int k = 0; k < 3; k++)
          c[k*npc_pkg::CH_W +: npc_pkg::CH_W] = {npc_pkg::CH_W{$urandom_range(0, 1) == 1}};
      end
      default: begin
        // midpoints between two entries, which can land on ties between them
        for (int k = 0; k < 3; k++)
          c[k*npc_pkg::CH_W +: npc_pkg::CH_W] =
            npc_pkg::CH_W'(({1'b0, a[k*npc_pkg::CH_W +: npc_pkg::CH_W]}
                            + b[k*npc_pkg::CH_W +: npc_pkg::CH_W]) >> 1);
      end
    endcase
    return c;
  endfunction

  initial begin : result_sink
    int stall;
    forever begin
      stall = recv_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    #(8 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    palette_kind_t kind;
    for (int i = 0; i < npc_pkg::PAL_REGS; i++) palette_now[i] = npc_pkg::PAL_RESET[i];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_color(24'h000000);
    send_color(24'hFFFFFF);
    for (int i = 0; i < npc_pkg::PAL_REGS; i++) send_color(palette_now[i]);
    send_color(24'hF870C4);
    send_color(24'hFF0000);
    send_color(24'h00FF00);
    send_color(24'h0000FF);
    wait_idle();

    for (int i = 0; i < npc_pkg::PAL_REGS; i++) palette_now[i] = 24'hFFFFFF;
    palette_now[6] = 24'h000002;
    palette_now[7] = 24'h000000;
    write_palette();
    send_color(24'h000001);
    send_color(24'h000000);
    send_color(24'hFFFFFF);
    send_color(24'h7F7F7F);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      kind = (p < 6) ? palette_kind_t'(p) : palette_kind_t'($urandom_range(0, 5));
      send_idles = (p != 3);
      recv_idles = (p != 3) && (p != 6);
      fill_palette(kind);
      write_palette();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_color(random_color());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && inflight_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
